[hdl/assert_macros.svh]
// Assertion macros for the RTL, used by the queue. They compile to nothing when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg)
`define ASSERT_IMPLIES(label, clk, rst_n, pre, post, msg)
`endif
`endif

[hdl/ipv4rhc_pkg.sv]
package ipv4rhc_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam int PADDR_W = 3;
    localparam logic REG_LOCAL_IP = 1'b0;

    localparam logic [15:0] HDR_MIN_BYTES = 16'd20;
    localparam logic [3:0]  IPV4_VERSION  = 4'd4;
    localparam logic [3:0]  IHL_MIN       = 4'd5;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;

    localparam logic [2:0] VERDICT_DELIVER     = 3'd0;
    localparam logic [2:0] VERDICT_PROTO_UNRCH = 3'd1;
    localparam logic [2:0] VERDICT_SHORT       = 3'd2;
    localparam logic [2:0] VERDICT_BAD_VER_LEN = 3'd3;
    localparam logic [2:0] VERDICT_NOT_OURS    = 3'd4;
    localparam logic [2:0] VERDICT_BAD_CSUM    = 3'd5;
    localparam logic [2:0] VERDICT_BAD_HLEN    = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [2:0]  verdict;
        logic [7:0]  protocol;
        logic [31:0] source_ip;
        logic [5:0]  header_bytes;
        logic [15:0] payload_bytes;
    } out_t;

    // Everything the back end needs to judge one finished packet.
    typedef struct packed {
        logic [15:0] byte_count;
        logic [7:0]  version_ihl;
        logic [15:0] total_length;
        logic [7:0]  protocol_byte;
        logic [31:0] source_addr;
        logic [31:0] dest_addr;
        logic [15:0] stored_checksum;
        logic [16:0] sum_accumulator;
    } pkt_rec_t;

    typedef struct packed {
        logic     push;
        pkt_rec_t rec;
    } q_wr_t;

    typedef struct packed {
        logic     not_empty;
        pkt_rec_t rec;
    } q_rd_t;

endpackage

[hdl/ipv4rhc_front.sv]
module ipv4rhc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  ipv4rhc_pkg::in_t    in_data,
    input  logic                q_full,
    output ipv4rhc_pkg::q_wr_t  q_wr
);

    logic [15:0] byte_count_reg, byte_count_next;
    logic [7:0]  version_ihl_reg, version_ihl_next;
    logic [15:0] total_length_reg, total_length_next;
    logic [7:0]  protocol_byte_reg, protocol_byte_next;
    logic [31:0] source_addr_reg, source_addr_next;
    logic [31:0] dest_addr_reg, dest_addr_next;
    logic [15:0] stored_checksum_reg, stored_checksum_next;
    logic [16:0] sum_reg, sum_next;
    logic [7:0]  high_byte_hold_reg, high_byte_hold_next;

    logic        in_fire;
    logic [15:0] idx;
    logic [7:0]  b;
    logic [7:0]  v;
    logic [5:0]  hlen;
    logic [16:0] word_sum;

    assign in_ready = !q_full;
    assign in_fire  = in_valid && in_ready;
    assign idx      = byte_count_reg;
    assign b        = in_data.data_byte;

    always_comb
    begin
        version_ihl_next     = version_ihl_reg;
        total_length_next    = total_length_reg;
        protocol_byte_next   = protocol_byte_reg;
        source_addr_next     = source_addr_reg;
        dest_addr_next       = dest_addr_reg;
        stored_checksum_next = stored_checksum_reg;
        sum_next             = sum_reg;
        high_byte_hold_next  = high_byte_hold_reg;

        case (idx)
            16'd0:  version_ihl_next            = b;
            16'd2:  total_length_next[15:8]     = b;
            16'd3:  total_length_next[7:0]      = b;
            16'd9:  protocol_byte_next          = b;
            16'd10: stored_checksum_next[15:8]  = b;
            16'd11: stored_checksum_next[7:0]   = b;
            16'd12: source_addr_next[31:24]     = b;
            16'd13: source_addr_next[23:16]     = b;
            16'd14: source_addr_next[15:8]      = b;
            16'd15: source_addr_next[7:0]       = b;
            16'd16: dest_addr_next[31:24]       = b;
            16'd17: dest_addr_next[23:16]       = b;
            16'd18: dest_addr_next[15:8]        = b;
            16'd19: dest_addr_next[7:0]         = b;
            default: ;
        endcase

        // The header length used here already reflects the first byte.
        hlen     = {version_ihl_next[3:0], 2'b00};
        v        = (idx == 16'd10 || idx == 16'd11) ? 8'd0 : b;
        word_sum = sum_reg + {1'b0, high_byte_hold_reg, v};
        if (idx < {10'd0, hlen})
        begin
            if (!idx[0])
            begin
                high_byte_hold_next = v;
            end
            else
            begin
                sum_next = {1'b0, word_sum[15:0]} + {16'd0, word_sum[16]};
            end
        end

        byte_count_next = (byte_count_reg == 16'hFFFF) ? byte_count_reg
                                                        : byte_count_reg + 16'd1;
    end

    always_comb
    begin
        q_wr.push                 = in_fire && in_data.last_byte;
        q_wr.rec.byte_count       = byte_count_next;
        q_wr.rec.version_ihl      = version_ihl_next;
        q_wr.rec.total_length     = total_length_next;
        q_wr.rec.protocol_byte    = protocol_byte_next;
        q_wr.rec.source_addr      = source_addr_next;
        q_wr.rec.dest_addr        = dest_addr_next;
        q_wr.rec.stored_checksum  = stored_checksum_next;
        q_wr.rec.sum_accumulator  = sum_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg      <= '0;
            version_ihl_reg     <= '0;
            total_length_reg    <= '0;
            protocol_byte_reg   <= '0;
            source_addr_reg     <= '0;
            dest_addr_reg       <= '0;
            stored_checksum_reg <= '0;
            sum_reg             <= '0;
            high_byte_hold_reg  <= '0;
        end
        else if (in_fire)
        begin
            if (in_data.last_byte)
            begin
                // The packet has gone to the queue; start afresh.
                byte_count_reg      <= '0;
                version_ihl_reg     <= '0;
                total_length_reg    <= '0;
                protocol_byte_reg   <= '0;
                source_addr_reg     <= '0;
                dest_addr_reg       <= '0;
                stored_checksum_reg <= '0;
                sum_reg             <= '0;
                high_byte_hold_reg  <= '0;
            end
            else
            begin
                byte_count_reg      <= byte_count_next;
                version_ihl_reg     <= version_ihl_next;
                total_length_reg    <= total_length_next;
                protocol_byte_reg   <= protocol_byte_next;
                source_addr_reg     <= source_addr_next;
                dest_addr_reg       <= dest_addr_next;
                stored_checksum_reg <= stored_checksum_next;
                sum_reg             <= sum_next;
                high_byte_hold_reg  <= high_byte_hold_next;
            end
        end
    end

endmodule

[hdl/ipv4rhc_queue.sv]
`include "assert_macros.svh"

module ipv4rhc_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  ipv4rhc_pkg::q_wr_t  q_wr,
    output logic                q_full,
    input  logic                pop,
    output ipv4rhc_pkg::q_rd_t  q_rd
);

    ipv4rhc_pkg::pkt_rec_t entry_reg [ipv4rhc_pkg::QUEUE_DEPTH];

    logic [ipv4rhc_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ipv4rhc_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [ipv4rhc_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    logic do_push;
    logic do_pop;

    localparam logic [ipv4rhc_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
        ipv4rhc_pkg::QUEUE_PTR_W'(ipv4rhc_pkg::QUEUE_DEPTH - 1);
    localparam logic [ipv4rhc_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
        ipv4rhc_pkg::QUEUE_CNT_W'(ipv4rhc_pkg::QUEUE_DEPTH);

    assign q_full         = (count_reg == CNT_FULL);
    assign q_rd.not_empty = (count_reg != '0);
    assign q_rd.rec       = entry_reg[rd_ptr_reg];

    assign do_push = q_wr.push && !q_full;
    assign do_pop  = pop && q_rd.not_empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= q_wr.rec;
        end
    end

    `ASSERT_ALWAYS(a_count_in_range, clk, rst_n, count_reg <= CNT_FULL, "queue count overflow")
    `ASSERT_ALWAYS(a_no_push_full, clk, rst_n, !(q_wr.push && q_full), "push into full queue")
    `ASSERT_IMPLIES(a_push_grows, clk, rst_n, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1, "queue count did not grow on push")

endmodule

[hdl/ipv4rhc_back.sv]
module ipv4rhc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [31:0]         local_ip,
    input  ipv4rhc_pkg::q_rd_t  q_rd,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_ready,
    output ipv4rhc_pkg::out_t   out_data
);

    logic               out_valid_reg, out_valid_next;
    ipv4rhc_pkg::out_t  out_data_reg;
    ipv4rhc_pkg::out_t  result;

    ipv4rhc_pkg::pkt_rec_t rec;
    logic [3:0]  ihl;
    logic [5:0]  hlen;
    logic [16:0] fold1;
    logic [15:0] fold2;
    logic [15:0] calc;
    logic [2:0]  verdict;

    assign rec = q_rd.rec;
    assign pop = q_rd.not_empty && (!out_valid_reg || out_ready);

    always_comb
    begin
        ihl   = rec.version_ihl[3:0];
        hlen  = {ihl, 2'b00};
        fold1 = {1'b0, rec.sum_accumulator[15:0]} + {16'd0, rec.sum_accumulator[16]};
        fold2 = fold1[15:0] + {15'd0, fold1[16]};
        calc  = ~fold2;

        if (rec.byte_count < ipv4rhc_pkg::HDR_MIN_BYTES)
        begin
            verdict = ipv4rhc_pkg::VERDICT_SHORT;
        end
        else if (rec.version_ihl[7:4] != ipv4rhc_pkg::IPV4_VERSION
                 || rec.total_length > rec.byte_count)
        begin
            verdict = ipv4rhc_pkg::VERDICT_BAD_VER_LEN;
        end
        else if (ihl < ipv4rhc_pkg::IHL_MIN || {10'd0, hlen} > rec.total_length)
        begin
            verdict = ipv4rhc_pkg::VERDICT_BAD_HLEN;
        end
        else if (rec.dest_addr != local_ip)
        begin
            verdict = ipv4rhc_pkg::VERDICT_NOT_OURS;
        end
        else if (calc != rec.stored_checksum)
        begin
            verdict = ipv4rhc_pkg::VERDICT_BAD_CSUM;
        end
        else if (rec.protocol_byte == ipv4rhc_pkg::PROTO_UDP
                 || rec.protocol_byte == ipv4rhc_pkg::PROTO_ICMP)
        begin
            verdict = ipv4rhc_pkg::VERDICT_DELIVER;
        end
        else
        begin
            verdict = ipv4rhc_pkg::VERDICT_PROTO_UNRCH;
        end

        result.verdict      = verdict;
        result.protocol     = rec.protocol_byte;
        result.source_ip    = rec.source_addr;
        result.header_bytes = hlen;
        result.payload_bytes = (verdict == ipv4rhc_pkg::VERDICT_DELIVER
                                || verdict == ipv4rhc_pkg::VERDICT_PROTO_UNRCH)
                               ? rec.total_length - {10'd0, hlen} : 16'd0;
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_data_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

[hdl/ipv4_receive_header_check_core.sv]
// IPv4 receive header check.
// The input channel (in_valid, in_ready, in_data) carries one packet byte per
// transfer in wire order, with last_byte set on the final byte of the packet.
// The output channel (out_valid, out_ready, out_data) carries one verdict per
// packet, together with the protocol, source address, header length and
// payload length. No result is produced for any other byte.
// Throughput is one byte per cycle unless the queue is full: the front end
// updates the running header checksum and captures each field as it arrives.
// A finished packet enters a two-entry queue at the edge that takes its last
// byte; the back end then registers its verdict into the output register,
// raising out_valid, whenever that register is empty or being read.
// When the receiver stalls, the output register holds its result and the queue
// absorbs up to two further packets; while the queue is full, in_ready stays
// low for every byte until a queued result moves into the output register.
// The user writes the local address over APB at address 0 only while idle;
// the block does not enforce this. Reset zeroes local_ip, empties the queue
// and output register and restarts byte counting at the first byte.
module ipv4_receive_header_check_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  ipv4rhc_pkg::in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output ipv4rhc_pkg::out_t                   out_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ipv4rhc_pkg::PADDR_W-1:0]     paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);

    logic [31:0]         local_ip_reg;
    logic                q_full;
    logic                pop;
    ipv4rhc_pkg::q_wr_t  q_wr;
    ipv4rhc_pkg::q_rd_t  q_rd;
    logic                reg_sel;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[ipv4rhc_pkg::PADDR_W-1] == ipv4rhc_pkg::REG_LOCAL_IP);
    assign prdata  = reg_sel ? local_ip_reg : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            local_ip_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && reg_sel)
        begin
            local_ip_reg <= pwdata;
        end
    end

    ipv4rhc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .q_full   (q_full),
        .q_wr     (q_wr)
    );

    ipv4rhc_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_wr   (q_wr),
        .q_full (q_full),
        .pop    (pop),
        .q_rd   (q_rd)
    );

    ipv4rhc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .local_ip  (local_ip_reg),
        .q_rd      (q_rd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

[dv/testbench.sv]
`timescale 1ns / 100ps

module testbench;

    localparam int CYCLE_LIMIT = 40000;
    localparam logic [ipv4rhc_pkg::PADDR_W-1:0] LOCAL_IP_ADDR =
        {ipv4rhc_pkg::REG_LOCAL_IP, 2'b00};

    // Tracks the header of the packet in flight and queues the verdict that each
    // packet end must produce.
    class verdict_scoreboard;
        logic [31:0]        local_ip;
        logic [15:0]        byte_count;
        logic [7:0]         version_ihl;
        logic [15:0]        total_length;
        logic [7:0]         protocol_byte;
        logic [31:0]        source_addr;
        logic [31:0]        dest_addr;
        logic [15:0]        stored_checksum;
        logic [16:0]        header_sum;
        logic [7:0]         high_byte;
        ipv4rhc_pkg::out_t  due_verdicts[$];
        int                 mismatches;
        int                 checked;
        int                 verdict_tally[8];

        function new();
            local_ip = '0;
            clear_packet();
        endfunction

        function void clear_packet();
            byte_count      = '0;
            version_ihl     = '0;
            total_length    = '0;
            protocol_byte   = '0;
            source_addr     = '0;
            dest_addr       = '0;
            stored_checksum = '0;
            header_sum      = '0;
            high_byte       = '0;
        endfunction

        function void note_byte(ipv4rhc_pkg::in_t item);
            int                 idx;
            int                 hlen;
            int                 len;
            int                 folded;
            logic [7:0]         word_byte;
            logic [15:0]        calc;
            ipv4rhc_pkg::out_t  want;
            idx = byte_count;
            if (idx == 0) version_ihl = item.data_byte;
            else if (idx == 2) total_length[15:8] = item.data_byte;
            else if (idx == 3) total_length[7:0] = item.data_byte;
            else if (idx == 9) protocol_byte = item.data_byte;
            else if (idx == 10) stored_checksum[15:8] = item.data_byte;
            else if (idx == 11) stored_checksum[7:0] = item.data_byte;
            else if (idx >= 12 && idx <= 15) source_addr[8 * (15 - idx) +: 8] = item.data_byte;
            else if (idx >= 16 && idx <= 19) dest_addr[8 * (19 - idx) +: 8] = item.data_byte;

            // Only the first IHL*4 bytes enter the sum, with the checksum field as zero.
            hlen = 4 * version_ihl[3:0];
            if (idx < hlen)
            begin
                word_byte = (idx == 10 || idx == 11) ? 8'h00 : item.data_byte;
                if (idx % 2 == 0)
                begin
                    high_byte = word_byte;
                end
                else
                begin
                    folded = header_sum + {high_byte, word_byte};
                    folded = (folded & 'hFFFF) + (folded >> 16);
                    header_sum = folded[16:0];
                end
            end
            if (byte_count != 16'hFFFF) byte_count++;
            if (!item.last_byte) return;

            len = byte_count;
            folded = header_sum[15:0] + header_sum[16];
            folded = (folded & 'hFFFF) + (folded >> 16);
            calc = ~folded[15:0];
            if (len < ipv4rhc_pkg::HDR_MIN_BYTES)
                want.verdict = ipv4rhc_pkg::VERDICT_SHORT;
            else if (version_ihl[7:4] != ipv4rhc_pkg::IPV4_VERSION || total_length > len)
                want.verdict = ipv4rhc_pkg::VERDICT_BAD_VER_LEN;
            else if (version_ihl[3:0] < ipv4rhc_pkg::IHL_MIN || hlen > total_length)
                want.verdict = ipv4rhc_pkg::VERDICT_BAD_HLEN;
            else if (dest_addr != local_ip)
                want.verdict = ipv4rhc_pkg::VERDICT_NOT_OURS;
            else if (calc != stored_checksum)
                want.verdict = ipv4rhc_pkg::VERDICT_BAD_CSUM;
            else if (protocol_byte == ipv4rhc_pkg::PROTO_UDP ||
                     protocol_byte == ipv4rhc_pkg::PROTO_ICMP)
                want.verdict = ipv4rhc_pkg::VERDICT_DELIVER;
            else
                want.verdict = ipv4rhc_pkg::VERDICT_PROTO_UNRCH;
            want.protocol      = protocol_byte;
            want.source_ip     = source_addr;
            want.header_bytes  = 6'(hlen);
            want.payload_bytes = (want.verdict == ipv4rhc_pkg::VERDICT_DELIVER ||
                                  want.verdict == ipv4rhc_pkg::VERDICT_PROTO_UNRCH) ?
                                 16'(total_length - hlen) : 16'h0000;
            due_verdicts.push_back(want);
            clear_packet();
        endfunction

        function void check_verdict(ipv4rhc_pkg::out_t got);
            ipv4rhc_pkg::out_t want;
            if (due_verdicts.size() == 0)
            begin
                $error("Result transfer with no packet outstanding: verdict %0d", got.verdict);
                mismatches++;
                return;
            end
            want = due_verdicts.pop_front();
            checked++;
            verdict_tally[want.verdict]++;
            if (got.verdict !== want.verdict)
            begin
                $error("verdict: expected %0d, got %0d", want.verdict, got.verdict);
                mismatches++;
            end
            if (got.protocol !== want.protocol)
            begin
                $error("protocol: expected %0d, got %0d", want.protocol, got.protocol);
                mismatches++;
            end
            if (got.source_ip !== want.source_ip)
            begin
                $error("source_ip: expected %h, got %h", want.source_ip, got.source_ip);
                mismatches++;
            end
            if (got.header_bytes !== want.header_bytes)
            begin
                $error("header_bytes: expected %0d, got %0d", want.header_bytes,
                       got.header_bytes);
                mismatches++;
            end
            if (got.payload_bytes !== want.payload_bytes)
            begin
                $error("payload_bytes: expected %0d, got %0d", want.payload_bytes,
                       got.payload_bytes);
                mismatches++;
            end
        endfunction
    endclass

    logic                               clk       = 1'b0;
    logic                               rst_n     = 1'b0;
    logic                               in_valid  = 1'b0;
    logic                               in_ready;
    ipv4rhc_pkg::in_t                   in_data   = '0;
    logic                               out_valid;
    logic                               out_ready = 1'b0;
    ipv4rhc_pkg::out_t                  out_data;
    logic                               psel      = 1'b0;
    logic                               penable   = 1'b0;
    logic                               pwrite    = 1'b0;
    logic [ipv4rhc_pkg::PADDR_W-1:0]    paddr     = '0;
    logic [31:0]                        pwdata    = '0;
    logic [31:0]                        prdata;
    logic                               pready;

    verdict_scoreboard sb;
    logic [7:0]        pkt[$];
    int                send_idle_pct = 0;
    int                recv_idle_pct = 0;
    int                hold_requests = 0;
    int                hold_seen     = 0;
    int                hold_left     = 0;
    int                bytes_sent    = 0;
    int                packets_sent  = 0;
    int                ip_writes     = 0;
    int                cycles_run    = 0;

    ipv4_receive_header_check_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off whenever the sender asks for one.
    always @(posedge clk)
    begin
        if (hold_requests != hold_seen)
        begin
            hold_seen = hold_requests;
            hold_left = 300;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready) sb.check_verdict(out_data);
    end

    initial
    begin
        while (cycles_run < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles_run++;
        end
        $error("No progress after %0d cycles; %0d results still outstanding",
               CYCLE_LIMIT, sb.due_verdicts.size());
        $display("status: fail");
        $finish;
    end

    function automatic logic [15:0] header_checksum(int hlen);
        int s;
        s = 0;
        for (int i = 0; i + 1 < hlen; i += 2)
        begin
            s = s + {pkt[i], pkt[i + 1]};
            s = (s & 'hFFFF) + (s >> 16);
        end
        s = (s & 'hFFFF) + (s >> 16);
        return ~s[15:0];
    endfunction

    // Builds a well-formed datagram with a correct header checksum, random options,
    // payload and trailing padding.
    function automatic void build_datagram(logic [3:0] ihl, logic [7:0] proto,
                                           logic [31:0] dst, int payload_len, int pad_len);
        int          hlen;
        logic [15:0] tot;
        logic [31:0] src;
        logic [15:0] csum;
        hlen = 4 * ihl;
        tot  = 16'(hlen + payload_len);
        src  = $urandom;
        pkt.delete();
        pkt.push_back({ipv4rhc_pkg::IPV4_VERSION, ihl});
        pkt.push_back(8'($urandom));
        pkt.push_back(tot[15:8]);
        pkt.push_back(tot[7:0]);
        repeat (5) pkt.push_back(8'($urandom));
        pkt.push_back(proto);
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        for (int i = 3; i >= 0; i--) pkt.push_back(src[8 * i +: 8]);
        for (int i = 3; i >= 0; i--) pkt.push_back(dst[8 * i +: 8]);
        while (pkt.size() < hlen) pkt.push_back(8'($urandom));
        csum = header_checksum(hlen);
        pkt[10] = csum[15:8];
        pkt[11] = csum[7:0];
        repeat (payload_len + pad_len) pkt.push_back(8'($urandom));
    endfunction

    function automatic void trim_packet(int n);
        while (pkt.size() > n) void'(pkt.pop_back());
    endfunction

    task automatic send_byte(ipv4rhc_pkg::in_t item);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_byte(item);
        bytes_sent++;
    endtask

    task automatic send_packet();
        ipv4rhc_pkg::in_t item;
        for (int i = 0; i < pkt.size(); i++)
        begin
            item.data_byte = pkt[i];
            item.last_byte = (i == pkt.size() - 1);
            send_byte(item);
        end
        packets_sent++;
    endtask

    // Mostly good datagrams with random content; the rest are damaged or plain noise.
    task automatic send_random_packet();
        int          kind;
        int          hlen;
        int          pos;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [31:0] dst;
        kind = $urandom_range(99);
        ihl  = ($urandom_range(3) == 0) ? 4'($urandom_range(15, 5)) : ipv4rhc_pkg::IHL_MIN;
        if (kind >= 84 && kind < 90) ihl = 4'd15;
        case ($urandom_range(3))
            0:       proto = ipv4rhc_pkg::PROTO_ICMP;
            1:       proto = 8'($urandom);
            default: proto = ipv4rhc_pkg::PROTO_UDP;
        endcase
        dst = ($urandom_range(9) == 0) ? 32'($urandom) : sb.local_ip;
        build_datagram(ihl, proto, dst, $urandom_range(40),
                       ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 0);
        hlen = 4 * ihl;
        if (kind >= 90)
        begin
            pkt.delete();
            repeat ($urandom_range(1, 48)) pkt.push_back(8'($urandom));
        end
        else if (kind >= 84)
        begin
            // A total length shorter than the 60-byte header.
            pkt[2] = 8'h00;
            pkt[3] = 8'($urandom_range(20, 59));
        end
        else if (kind >= 78)
        begin
            trim_packet($urandom_range(1, pkt.size() - 1));
        end
        else if (kind >= 73)
        begin
            pkt[0] = {ipv4rhc_pkg::IPV4_VERSION, 4'($urandom_range(4))};
        end
        else if (kind >= 68)
        begin
            pkt[0] = {4'($urandom_range(15)), ihl};
        end
        else if (kind >= 60)
        begin
            pos = $urandom_range(hlen - 1);
            pkt[pos] = pkt[pos] ^ 8'($urandom_range(1, 255));
        end
        send_packet();
    endtask

    task automatic run_random_phase(int byte_goal, int packet_goal);
        int bytes_at_start;
        int packets_at_start;
        bytes_at_start   = bytes_sent;
        packets_at_start = packets_sent;
        while (bytes_sent - bytes_at_start < byte_goal ||
               packets_sent - packets_at_start < packet_goal)
            send_random_packet();
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.due_verdicts.size() != 0) @(posedge clk);
    endtask

    task automatic write_local_ip(logic [31:0] value);
        drain_results();
        repeat (4) @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= LOCAL_IP_ADDR;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        sb.local_ip = value;
        ip_writes++;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== value)
        begin
            $error("local_ip readback: expected %h, got %h", value, prdata);
            sb.mismatches++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    initial
    begin
        sb = new();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 7;
        recv_idle_pct = 57;

        // A lone byte: every field but the first byte reads as zero.
        pkt.delete();
        pkt.push_back(8'hFF);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 0, 0);
        trim_packet(19);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 0, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_ICMP, sb.local_ip, 8, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, 8'd6, sb.local_ip, 4, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, 8'h00, sb.local_ip, 2, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, 8'hFF, sb.local_ip, 3, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 4, 0);
        pkt[0] = {4'd6, pkt[0][3:0]};
        send_packet();
        // The total length claims more bytes than the packet carries.
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 20, 0);
        trim_packet(20);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 4, 0);
        pkt[0] = {ipv4rhc_pkg::IPV4_VERSION, 4'd0};
        send_packet();
        pkt[0] = {ipv4rhc_pkg::IPV4_VERSION, 4'd4};
        send_packet();
        build_datagram(4'd15, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 0, 0);
        pkt[2] = 8'h00;
        pkt[3] = 8'd40;
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, ~sb.local_ip, 4, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 4, 0);
        pkt[11] = pkt[11] ^ 8'h01;
        send_packet();
        build_datagram(4'd15, ipv4rhc_pkg::PROTO_ICMP, sb.local_ip, 12, 0);
        send_packet();
        // Trailing padding past the total length must not change the verdict.
        build_datagram(4'd6, ipv4rhc_pkg::PROTO_UDP, sb.local_ip, 10, 7);
        send_packet();
        pkt.delete();
        repeat (20) pkt.push_back(8'h00);
        send_packet();
        pkt.delete();
        repeat (20) pkt.push_back(8'hFF);
        send_packet();

        write_local_ip(32'hFFFF_FFFF);
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_UDP, 32'hFFFF_FFFF, 6, 0);
        send_packet();
        build_datagram(ipv4rhc_pkg::IHL_MIN, ipv4rhc_pkg::PROTO_ICMP, 32'h0000_0000, 6, 0);
        send_packet();

        write_local_ip($urandom);
        run_random_phase(80, 4);
        // Hold the receiver off while short packets keep arriving, so the result
        // queue fills and the input stalls.
        hold_requests++;
        repeat (8)
        begin
            pkt.delete();
            repeat ($urandom_range(1, 3)) pkt.push_back(8'($urandom));
            send_packet();
        end
        drain_results();
        run_random_phase(80, 4);

        write_local_ip($urandom);
        send_idle_pct = 57;
        recv_idle_pct = 7;
        run_random_phase(140, 8);

        write_local_ip(32'h0000_0000);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random_phase(140, 8);
        run_random_phase(30, 2);

        drain_results();
        repeat (8) @(posedge clk);
        $display("Checked %0d packet verdicts over %0d bytes: %0d delivered, %0d unreachable.",
                 sb.checked, bytes_sent, sb.verdict_tally[ipv4rhc_pkg::VERDICT_DELIVER],
                 sb.verdict_tally[ipv4rhc_pkg::VERDICT_PROTO_UNRCH]);
        $display("Local address set %0d times; one long receiver hold-off stalled the input.",
                 ip_writes);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+hdl
hdl/ipv4rhc_pkg.sv
hdl/ipv4rhc_front.sv
hdl/ipv4rhc_queue.sv
hdl/ipv4rhc_back.sv
hdl/ipv4_receive_header_check_core.sv
dv/testbench.sv
